>>> rtl/core/su2_subgroup_extract_unit_assert.svh
// Assertion macros shared by the SU(2) subgroup extract RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef SU2_SUBGROUP_EXTRACT_UNIT_ASSERT_SVH
`define SU2_SUBGROUP_EXTRACT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SU2SE_ASSERT_ALWAYS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
    else $error("su2se check failed");
`define SU2SE_ASSERT_NEXT(lbl, ck, rn, ant, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (cons)) \
    else $error("su2se check failed");
`else
`define SU2SE_ASSERT_ALWAYS(lbl, ck, rn, expr)
`define SU2SE_ASSERT_NEXT(lbl, ck, rn, ant, cons)
`endif
`endif

>>> rtl/core/su2se_pkg.sv
// Package for the SU(2) subgroup extract unit: types, sizes, step functions.
// Depends on nothing.
`timescale 1ns / 1ps
package su2se_pkg;
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned SqrtSteps = 34;
  localparam int unsigned DivSteps  = 31;
  localparam logic [31:0] ThreshReset = 32'd1;

  // a, d, c, b and the sum of their squares
  typedef struct packed {
    logic [3:0][32:0] comp;
    logic [66:0]      sum;
  } front_t;

  typedef struct packed {
    logic [67:0]      rad;
    logic [37:0]      rem;
    logic [33:0]      root;
    logic [3:0][32:0] comp;
  } sq_t;

  typedef struct packed {
    logic [31:0]      xi;
    logic             norm;
    logic [33:0]      p;
    logic [3:0][34:0] rem;
    logic [3:0][30:0] q;
    logic [3:0][32:0] comp;
  } dv_t;

  function automatic logic [32:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  // one root bit per call
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t         o;
    logic [37:0] r2;
    logic [37:0] trial;
    o     = s;
    r2    = {s.rem[35:0], s.rad[67:66]};
    trial = {2'b00, s.root, 2'b01};
    o.rad = {s.rad[65:0], 2'b00};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {s.root[32:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[32:0], 1'b0};
    end
    return o;
  endfunction

  // one quotient bit per lane per call
  function automatic dv_t div_step(input dv_t d);
    dv_t         o;
    logic [34:0] r;
    logic        qb;
    o = d;
    for (int k = 0; k < 4; k++) begin
      qb = (d.rem[k] >= {1'b0, d.p});
      r  = qb ? (d.rem[k] - {1'b0, d.p}) : d.rem[k];
      o.rem[k] = {r[33:0], 1'b0};
      o.q[k]   = {d.q[k][29:0], qb};
    end
    return o;
  endfunction

  // Q.24 to Q2.30 with saturation
  function automatic logic [31:0] raw_q30(input logic [32:0] x);
    if (!x[32] && (x[31:25] != 7'd0)) return 32'h7FFF_FFFF;
    if (x[32] && (x[31:25] != 7'h7F)) return 32'h8000_0000;
    return {x[25:0], 6'b0};
  endfunction
endpackage

>>> rtl/core/su2_subgroup_extract_unit.sv
// SU(2) subgroup extract unit: takes one 2x2 sub-block per transfer and
// returns half its norm plus the unit (or raw) quaternion. One item is
// taken per clock while in_ready is high. On its way to out_valid an item passes
// 3 front stages, the queue, 34 root stages, 32 division
// stages (decision plus 31 quotient bits) and the output register.
// Depends on su2se_pkg, su2se_front, su2se_fifo, su2se_back.
`timescale 1ns / 1ps
module su2_subgroup_extract_unit #(
  parameter logic [31:0] THRESH_RESET = su2se_pkg::ThreshReset
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_diag_first_re,
  input  logic signed [31:0] in_diag_first_im,
  input  logic signed [31:0] in_upper_off_re,
  input  logic signed [31:0] in_upper_off_im,
  input  logic signed [31:0] in_lower_off_re,
  input  logic signed [31:0] in_lower_off_im,
  input  logic signed [31:0] in_diag_second_re,
  input  logic signed [31:0] in_diag_second_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_half_norm,
  output logic signed [31:0] out_quat_zero,
  output logic signed [31:0] out_quat_one,
  output logic signed [31:0] out_quat_two,
  output logic signed [31:0] out_quat_three
);
  logic [31:0]       thresh_r;
  logic              fr_valid, fr_ready, bk_valid, bk_ready;
  su2se_pkg::front_t fr_data, bk_data;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_we) begin
      thresh_r <= cfg_wdata;
    end
  end

  su2se_front u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .diag_first_re (in_diag_first_re),  .diag_first_im (in_diag_first_im),
    .upper_off_re  (in_upper_off_re),   .upper_off_im  (in_upper_off_im),
    .lower_off_re  (in_lower_off_re),   .lower_off_im  (in_lower_off_im),
    .diag_second_re(in_diag_second_re), .diag_second_im(in_diag_second_im),
    .fr_valid, .fr_ready, .fr_data
  );

  su2se_fifo u_fifo (
    .clk, .rst_n,
    .push_valid(fr_valid), .push_ready(fr_ready), .push_data(fr_data),
    .pop_valid (bk_valid), .pop_ready (bk_ready), .pop_data (bk_data)
  );

  su2se_back u_back (
    .clk, .rst_n, .thresh(thresh_r),
    .bk_valid, .bk_ready, .bk_data,
    .out_valid, .out_ready,
    .half_norm (out_half_norm),
    .quat_zero (out_quat_zero), .quat_one  (out_quat_one),
    .quat_two  (out_quat_two),  .quat_three(out_quat_three)
  );
endmodule

>>> rtl/core/su2se_front.sv
// Front end: accepts the four complex entries, forms a, d, c, b and the
// sum of squares over three registered stages. Uses su2se_pkg.
`timescale 1ns / 1ps
module su2se_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    diag_first_re,
  input  logic signed [31:0]    diag_first_im,
  input  logic signed [31:0]    upper_off_re,
  input  logic signed [31:0]    upper_off_im,
  input  logic signed [31:0]    lower_off_re,
  input  logic signed [31:0]    lower_off_im,
  input  logic signed [31:0]    diag_second_re,
  input  logic signed [31:0]    diag_second_im,
  output logic                  fr_valid,
  input  logic                  fr_ready,
  output su2se_pkg::front_t     fr_data
);
  logic [2:0]       v_r;
  logic [3:0][32:0] c1_r, c2_r;
  logic [3:0][65:0] sq_r;
  su2se_pkg::front_t f3_r;
  logic             en;

  // whole chain moves when its last stage is empty or drains
  assign en       = !v_r[2] || fr_ready;
  assign in_ready = en;
  assign fr_valid = v_r[2];
  assign fr_data  = f3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  // stage 1: sums and differences; stage 2: squares; stage 3: total
  always_ff @(posedge clk) begin
    if (en) begin
      c1_r[0] <= {diag_first_re[31], diag_first_re} + {diag_second_re[31], diag_second_re};
      c1_r[1] <= {upper_off_im[31], upper_off_im} + {lower_off_im[31], lower_off_im};
      c1_r[2] <= {upper_off_re[31], upper_off_re} - {lower_off_re[31], lower_off_re};
      c1_r[3] <= {diag_first_im[31], diag_first_im} - {diag_second_im[31], diag_second_im};
      c2_r    <= c1_r;
      for (int k = 0; k < 4; k++) begin
        sq_r[k] <= su2se_pkg::mag33(c1_r[k]) * su2se_pkg::mag33(c1_r[k]);
      end
      f3_r.comp <= c2_r;
      f3_r.sum  <= {1'b0, sq_r[0]} + {1'b0, sq_r[1]} + {1'b0, sq_r[2]} + {1'b0, sq_r[3]};
    end
  end
endmodule

>>> rtl/core/su2se_fifo.sv
// Short queue between front end and back end.
// Uses su2se_pkg and the assertion header.
`timescale 1ns / 1ps
`include "su2_subgroup_extract_unit_assert.svh"
module su2se_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  su2se_pkg::front_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output su2se_pkg::front_t pop_data
);
  su2se_pkg::front_t mem_r [su2se_pkg::FifoDepth];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic              push, pop;

  assign push_ready = (cnt_r != 2'(su2se_pkg::FifoDepth));
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `SU2SE_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= 2'(su2se_pkg::FifoDepth))
  `SU2SE_ASSERT_NEXT(a_full_after_two, clk, rst_n, cnt_r == 2'd1 && push && !pop, !push_ready)
  `SU2SE_ASSERT_ALWAYS(a_ptr_match, clk, rst_n, (cnt_r == 2'd1) == (wp_r != rp_r))
endmodule

>>> rtl/core/su2se_back.sv
// Back end: pipelined square root, per-lane division and result select.
// Uses su2se_pkg.
`timescale 1ns / 1ps
module su2se_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       thresh,
  input  logic              bk_valid,
  output logic              bk_ready,
  input  su2se_pkg::front_t bk_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       half_norm,
  output logic signed [31:0] quat_zero,
  output logic signed [31:0] quat_one,
  output logic signed [31:0] quat_two,
  output logic signed [31:0] quat_three
);
  localparam int unsigned NS = su2se_pkg::SqrtSteps;
  localparam int unsigned ND = su2se_pkg::DivSteps;

  su2se_pkg::sq_t  sq_r [NS];
  su2se_pkg::dv_t  dv_r [ND + 1];
  logic [NS-1:0]   sv_r;
  logic [ND:0]     dvv_r;
  logic            ov_r;
  logic [31:0]     xi_r;
  logic [3:0][31:0] q_r;
  su2se_pkg::sq_t  sq_in;
  su2se_pkg::dv_t  dv_in;
  logic [32:0]     xi_w;
  logic            en;

  // one global advance; the output register is the last stage
  assign en       = !ov_r || out_ready;
  assign bk_ready = en;
  assign out_valid  = ov_r;
  assign half_norm  = xi_r;
  assign quat_zero  = q_r[0];
  assign quat_one   = q_r[1];
  assign quat_two   = q_r[2];
  assign quat_three = q_r[3];

  always_comb begin
    sq_in.rad  = {1'b0, bk_data.sum};
    sq_in.rem  = '0;
    sq_in.root = '0;
    sq_in.comp = bk_data.comp;
  end

  // p = root, xi = p/2 saturated, normalize decision
  always_comb begin
    xi_w        = sq_r[NS-1].root[33:1];
    dv_in.xi    = xi_w[32] ? 32'hFFFF_FFFF : xi_w[31:0];
    dv_in.norm  = (dv_in.xi > thresh);
    dv_in.p     = sq_r[NS-1].root;
    dv_in.comp  = sq_r[NS-1].comp;
    dv_in.q     = '0;
    for (int k = 0; k < 4; k++) begin
      dv_in.rem[k] = {2'b00, su2se_pkg::mag33(sq_r[NS-1].comp[k])};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r  <= '0;
      dvv_r <= '0;
      ov_r  <= 1'b0;
    end else if (en) begin
      sv_r  <= {sv_r[NS-2:0], bk_valid};
      dvv_r <= {dvv_r[ND-1:0], sv_r[NS-1]};
      ov_r  <= dvv_r[ND];
    end
  end

  // root stages, division stages, final select
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= su2se_pkg::sqrt_step(sq_in);
      for (int s = 1; s < NS; s++) begin
        sq_r[s] <= su2se_pkg::sqrt_step(sq_r[s-1]);
      end
      dv_r[0] <= dv_in;
      for (int s = 1; s <= ND; s++) begin
        dv_r[s] <= su2se_pkg::div_step(dv_r[s-1]);
      end
      xi_r <= dv_r[ND].xi;
      for (int k = 0; k < 4; k++) begin
        if (dv_r[ND].norm) begin
          q_r[k] <= dv_r[ND].comp[k][32] ? (32'd0 - {1'b0, dv_r[ND].q[k]})
                                         : {1'b0, dv_r[ND].q[k]};
        end else begin
          q_r[k] <= su2se_pkg::raw_q30(dv_r[ND].comp[k]);
        end
      end
    end
  end
endmodule
